### rtl/bbgr_pkg.sv
// Shared types and constants for the baseband global register block.
// Holds command and register-select codes and the decoded operation record.
// No dependencies.
`default_nettype none

package bbgr_pkg;

  localparam int COUNT_WIDTH     = 10;
  localparam int ACQ_COUNT_WIDTH = 24;
  localparam int FLAG_WIDTH      = 12;
  localparam int DATA_WIDTH      = 32;
  localparam int QUEUE_DEPTH     = 2;
  localparam int QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  localparam int FLAG_TRACK_BIT  = 8;
  localparam int FLAG_PERIOD_BIT = 9;
  localparam int FLAG_REQ_BIT    = 10;
  localparam int FLAG_ACQ_BIT    = 11;
  localparam int ENABLE_BIT      = 8;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_READ,
    CMD_TICK,
    CMD_LOAD
  } cmd_t;

  typedef enum logic [2:0] {
    SEL_ENABLE,
    SEL_TRACK_START,
    SEL_MEAS_PERIOD,
    SEL_MEAS_COUNT,
    SEL_FLAGS,
    SEL_REQ_COUNT,
    SEL_MASK,
    SEL_NONE
  } sel_t;

  typedef struct packed {
    logic                  wr;
    logic                  rd;
    logic                  tick;
    logic                  load;
    sel_t                  sel;
    logic [DATA_WIDTH-1:0] data;
    logic                  done;
  } op_t;

  typedef struct packed {
    logic push;
    logic full;
  } push_ctl_t;

  typedef struct packed {
    logic pop;
    logic empty;
  } pop_ctl_t;

endpackage

`default_nettype wire

### rtl/bbgr_if.sv
// Handshake channel interfaces for the baseband global register block.
// Depends on nothing; payload widths match the item fields.
`default_nettype none

interface bbgr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [2:0]  reg_select;
  logic [31:0] write_data;
  logic        tracking_done;

  modport source(output valid, command, reg_select, write_data, tracking_done,
                 input ready);
  modport sink(input valid, command, reg_select, write_data, tracking_done,
               output ready);
endinterface

interface bbgr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        irq;

  modport source(output valid, read_data, irq, input ready);
  modport sink(input valid, read_data, irq, output ready);
endinterface

`default_nettype wire

### rtl/bbgr_front.sv
// Front stage: accept items and classify them into decoded operations.
// Depends on bbgr_pkg and bbgr_in_if.
`default_nettype none

module bbgr_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  bbgr_in_if.sink                  in_ch,
  input  wire logic                q_full,
  output bbgr_pkg::push_ctl_t      push_ctl,
  output bbgr_pkg::op_t            push_op
);

  logic          valid_r;
  logic          valid_nxt;
  bbgr_pkg::op_t op_r;
  bbgr_pkg::op_t op_nxt;
  logic          accept;
  logic          push;

  assign push         = valid_r && !q_full;
  assign in_ch.ready  = !valid_r || !q_full;
  assign accept       = in_ch.valid && in_ch.ready;

  always_comb begin
    op_nxt      = '0;
    op_nxt.sel  = bbgr_pkg::sel_t'(in_ch.reg_select);
    op_nxt.data = in_ch.write_data;
    op_nxt.done = in_ch.tracking_done;
    unique case (bbgr_pkg::cmd_t'(in_ch.command))
      bbgr_pkg::CMD_WRITE: op_nxt.wr   = 1'b1;
      bbgr_pkg::CMD_READ:  op_nxt.rd   = 1'b1;
      bbgr_pkg::CMD_TICK:  op_nxt.tick = 1'b1;
      bbgr_pkg::CMD_LOAD:  op_nxt.load = 1'b1;
      default:             op_nxt.load = 1'b1;
    endcase
  end

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (push) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= op_nxt;
    end
  end

  assign push_ctl.push = push;
  assign push_ctl.full = q_full;
  assign push_op       = op_r;

endmodule

`default_nettype wire

### rtl/bbgr_queue.sv
// Short queue of decoded operations between front and back stages.
// Depends on bbgr_pkg.
`default_nettype none

module bbgr_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire bbgr_pkg::push_ctl_t push_ctl,
  input  wire bbgr_pkg::op_t       push_op,
  input  wire logic                pop,
  output wire logic                full,
  output bbgr_pkg::pop_ctl_t       pop_ctl,
  output bbgr_pkg::op_t            pop_op
);

  bbgr_pkg::op_t                        mem_r [bbgr_pkg::QUEUE_DEPTH];
  logic [bbgr_pkg::QUEUE_PTR_W-1:0]     wr_ptr_r;
  logic [bbgr_pkg::QUEUE_PTR_W-1:0]     rd_ptr_r;
  logic [bbgr_pkg::QUEUE_CNT_W-1:0]     count_r;
  logic [bbgr_pkg::QUEUE_CNT_W-1:0]     count_nxt;
  logic                                 do_push;
  logic                                 do_pop;
  logic                                 empty;

  assign empty   = (count_r == '0);
  assign full    = (count_r == bbgr_pkg::QUEUE_CNT_W'(bbgr_pkg::QUEUE_DEPTH));
  assign do_push = push_ctl.push && !push_ctl.full;
  assign do_pop  = pop && !empty;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == bbgr_pkg::QUEUE_PTR_W'(bbgr_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == bbgr_pkg::QUEUE_PTR_W'(bbgr_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

  assign pop_ctl.pop   = do_pop;
  assign pop_ctl.empty = empty;
  assign pop_op        = mem_r[rd_ptr_r];

endmodule

`default_nettype wire

### rtl/bbgr_back.sv
// Back stage: register file, tick counters, sticky flags and result register.
// Depends on bbgr_pkg and bbgr_out_if.
`default_nettype none

module bbgr_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire bbgr_pkg::pop_ctl_t  q_ctl,
  input  wire bbgr_pkg::op_t       op,
  output wire logic                pop,
  bbgr_out_if.source               out_ch
);

  localparam int CW = bbgr_pkg::COUNT_WIDTH;
  localparam int AW = bbgr_pkg::ACQ_COUNT_WIDTH;
  localparam int FW = bbgr_pkg::FLAG_WIDTH;
  localparam int DW = bbgr_pkg::DATA_WIDTH;

  logic          en_r,     en_nxt;
  logic [CW-1:0] period_r, period_nxt;
  logic [CW-1:0] meas_r,   meas_nxt;
  logic [CW-1:0] req_r,    req_nxt;
  logic [AW-1:0] acq_r,    acq_nxt;
  logic [FW-1:0] flags_r,  flags_nxt;
  logic [DW-1:0] mask_r,   mask_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [DW-1:0] rdata_r,  rdata_nxt;
  logic          irq_r,    irq_nxt;
  logic [CW-1:0] meas_inc;

  assign pop      = !q_ctl.empty && (!out_valid_r || out_ch.ready);
  assign meas_inc = meas_r + 1'b1;

  always_comb begin
    en_nxt     = en_r;
    period_nxt = period_r;
    meas_nxt   = meas_r;
    req_nxt    = req_r;
    acq_nxt    = acq_r;
    flags_nxt  = flags_r;
    mask_nxt   = mask_r;
    rdata_nxt  = '0;

    if (op.wr) begin
      unique case (op.sel)
        bbgr_pkg::SEL_ENABLE:      if (op.data[bbgr_pkg::ENABLE_BIT]) en_nxt = 1'b1;
        bbgr_pkg::SEL_MEAS_PERIOD: period_nxt = op.data[CW-1:0];
        bbgr_pkg::SEL_MEAS_COUNT:  meas_nxt   = op.data[CW-1:0];
        bbgr_pkg::SEL_FLAGS:       flags_nxt  = flags_r & ~op.data[FW-1:0];
        bbgr_pkg::SEL_REQ_COUNT:   req_nxt    = op.data[CW-1:0];
        bbgr_pkg::SEL_MASK:        mask_nxt   = op.data;
        default: ;
      endcase
    end

    if (op.rd) begin
      unique case (op.sel)
        bbgr_pkg::SEL_ENABLE:      rdata_nxt[bbgr_pkg::ENABLE_BIT] = en_r;
        bbgr_pkg::SEL_MEAS_PERIOD: rdata_nxt = DW'(period_r);
        bbgr_pkg::SEL_MEAS_COUNT:  rdata_nxt = DW'(meas_r);
        bbgr_pkg::SEL_FLAGS:       rdata_nxt = DW'(flags_r);
        bbgr_pkg::SEL_REQ_COUNT:   rdata_nxt = DW'(req_r);
        bbgr_pkg::SEL_MASK:        rdata_nxt = mask_r;
        default:                   rdata_nxt = '0;
      endcase
    end

    if (op.tick) begin
      if (en_r) begin
        if (op.done) flags_nxt[bbgr_pkg::FLAG_TRACK_BIT] = 1'b1;
        if (meas_inc == period_r) begin
          meas_nxt = '0;
          flags_nxt[bbgr_pkg::FLAG_PERIOD_BIT] = 1'b1;
        end else begin
          meas_nxt = meas_inc;
        end
      end
      if (req_r != '0) begin
        req_nxt = req_r - 1'b1;
        if (req_r == CW'(1)) flags_nxt[bbgr_pkg::FLAG_REQ_BIT] = 1'b1;
      end
      if (acq_r != '0) begin
        acq_nxt = acq_r - 1'b1;
        if (acq_r == AW'(1)) flags_nxt[bbgr_pkg::FLAG_ACQ_BIT] = 1'b1;
      end
    end

    if (op.load) begin
      acq_nxt = op.data[AW-1:0];
    end

    irq_nxt = |(DW'(flags_nxt) & mask_nxt);
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r        <= 1'b0;
      period_r    <= '0;
      meas_r      <= '0;
      req_r       <= '0;
      acq_r       <= '0;
      flags_r     <= '0;
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_ctl.pop) begin
        en_r     <= en_nxt;
        period_r <= period_nxt;
        meas_r   <= meas_nxt;
        req_r    <= req_nxt;
        acq_r    <= acq_nxt;
        flags_r  <= flags_nxt;
        mask_r   <= mask_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_ctl.pop) begin
      rdata_r <= rdata_nxt;
      irq_r   <= irq_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.read_data = rdata_r;
  assign out_ch.irq       = irq_r;

endmodule

`default_nettype wire

### rtl/baseband_global_irq_regs.sv
// Top level of the baseband global register file and interrupt logic.
// Depends on bbgr_pkg, bbgr_if, bbgr_front, bbgr_queue and bbgr_back.
//
// Usage:
//   in_ch carries one item per handshake: command (write, read, tick, load
//   of the acquisition countdown), reg_select, write_data and tracking_done.
//   out_ch returns exactly one item per input item, in order: read_data
//   (register value on reads, zero otherwise) and irq (masked flag level
//   after the item is applied).
//   With no stalls the item passes three registers in order: the front
//   register, which loads at the input handshake, the two-entry queue, and
//   the back stage's result register, whose load also raises out_ch.valid.
//   Throughput is one item per cycle while out_ch.ready stays high; every
//   item updates the back stage's registers once, when it is popped.
//   When out_ch.ready is low the result register holds, the back stage
//   stops draining the queue, and in_ch.ready falls once the queue and the
//   front register are full; no item is lost or repeated.
//   A synchronous active-low reset clears the control registers, flags, mask
//   and pipeline, disabling the engine; the result register is not reset.
`default_nettype none

module baseband_global_irq_regs (
  input  wire logic    clk,
  input  wire logic    rst_n,
  bbgr_in_if.sink      in_ch,
  bbgr_out_if.source   out_ch
);

  bbgr_pkg::push_ctl_t push_ctl;
  bbgr_pkg::pop_ctl_t  pop_ctl;
  bbgr_pkg::op_t       push_op;
  bbgr_pkg::op_t       pop_op;
  logic                q_full;
  logic                pop;

  bbgr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push_ctl (push_ctl),
    .push_op  (push_op)
  );

  bbgr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_ctl (push_ctl),
    .push_op  (push_op),
    .pop      (pop),
    .full     (q_full),
    .pop_ctl  (pop_ctl),
    .pop_op   (pop_op)
  );

  bbgr_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_ctl  (pop_ctl),
    .op     (pop_op),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

### sim/tb.sv
// Testbench for baseband_global_irq_regs: register writes, reads, ticks and acquisition loads.
// A queue-fed driver and a self-checking monitor work against a register predictor.
// Depends on bbgr_pkg, the bbgr_if interfaces and the RTL top level.
`timescale 1ns / 1ps

module tb;
  import bbgr_pkg::*;

  localparam int STALL_LIMIT = 2000;

  typedef struct {
    cmd_t        cmd;
    sel_t        sel;
    logic [31:0] data;
    logic        done;
    int          idle_pct;
    int          stall_pct;
    bit          drain;
  } bus_op_t;

  typedef struct {
    logic [31:0] rd;
    logic        irq;
  } readback_t;

  logic clk;
  logic rst_n;

  bbgr_in_if  in_ch();
  bbgr_out_if out_ch();

  baseband_global_irq_regs i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  bus_op_t   stim_q[$];
  readback_t readback_q[$];
  bus_op_t   cur_op;
  int        rx_stall_pct = 0;
  int        ph_idle = 0;
  int        ph_stall = 0;
  int        errors = 0;
  int        idle_cycles = 0;

  logic                       eng_on = 1'b0;
  logic [COUNT_WIDTH-1:0]     meas_period = '0;
  logic [COUNT_WIDTH-1:0]     meas_count = '0;
  logic [COUNT_WIDTH-1:0]     req_left = '0;
  logic [ACQ_COUNT_WIDTH-1:0] acq_left = '0;
  logic [FLAG_WIDTH-1:0]      flags = '0;
  logic [DATA_WIDTH-1:0]      irq_mask = '0;

  task automatic apply_bus_op(input bus_op_t op, output logic [31:0] rd, output logic irq);
    rd = '0;
    case (op.cmd)
      CMD_WRITE: begin
        case (op.sel)
          SEL_ENABLE:      if (op.data[ENABLE_BIT]) eng_on = 1'b1;
          SEL_MEAS_PERIOD: meas_period = op.data[COUNT_WIDTH-1:0];
          SEL_MEAS_COUNT:  meas_count = op.data[COUNT_WIDTH-1:0];
          SEL_FLAGS:       flags = flags & ~op.data[FLAG_WIDTH-1:0];
          SEL_REQ_COUNT:   req_left = op.data[COUNT_WIDTH-1:0];
          SEL_MASK:        irq_mask = op.data;
          default: ;
        endcase
      end
      CMD_READ: begin
        case (op.sel)
          SEL_ENABLE:      rd[ENABLE_BIT] = eng_on;
          SEL_MEAS_PERIOD: rd[COUNT_WIDTH-1:0] = meas_period;
          SEL_MEAS_COUNT:  rd[COUNT_WIDTH-1:0] = meas_count;
          SEL_FLAGS:       rd[FLAG_WIDTH-1:0] = flags;
          SEL_REQ_COUNT:   rd[COUNT_WIDTH-1:0] = req_left;
          SEL_MASK:        rd = irq_mask;
          default: ;
        endcase
      end
      CMD_TICK: begin
        if (eng_on) begin
          if (op.done) flags[FLAG_TRACK_BIT] = 1'b1;
          meas_count = meas_count + 1'b1;
          if (meas_count == meas_period) begin
            meas_count = '0;
            flags[FLAG_PERIOD_BIT] = 1'b1;
          end
        end
        if (req_left != '0) begin
          req_left = req_left - 1'b1;
          if (req_left == '0) flags[FLAG_REQ_BIT] = 1'b1;
        end
        if (acq_left != '0) begin
          acq_left = acq_left - 1'b1;
          if (acq_left == '0) flags[FLAG_ACQ_BIT] = 1'b1;
        end
      end
      default: acq_left = op.data[ACQ_COUNT_WIDTH-1:0];
    endcase
    irq = |({{(DATA_WIDTH-FLAG_WIDTH){1'b0}}, flags} & irq_mask);
  endtask

  task automatic queue_op(input cmd_t cmd, input sel_t sel, input logic [31:0] data,
                          input logic done, input bit drain);
    bus_op_t op;
    op.cmd       = cmd;
    op.sel       = sel;
    op.data      = data;
    op.done      = done;
    op.idle_pct  = ph_idle;
    op.stall_pct = ph_stall;
    op.drain     = drain;
    stim_q.push_back(op);
  endtask

  task automatic queue_random_op(input bit drain);
    int          r;
    sel_t        sel;
    logic [31:0] data;
    r    = $urandom_range(0, 99);
    sel  = sel_t'($urandom_range(0, 7));
    data = $urandom;
    if (r < 35) begin
      case (sel)
        SEL_MEAS_PERIOD, SEL_MEAS_COUNT, SEL_REQ_COUNT:
          if ($urandom_range(0, 3) != 0) data = $urandom_range(0, 12);
        SEL_MASK, SEL_FLAGS:
          if ($urandom_range(0, 1) != 0) data = 32'h1 << $urandom_range(8, 11);
        default: ;
      endcase
      queue_op(CMD_WRITE, sel, data, 1'($urandom_range(0, 1)), drain);
    end else if (r < 65) begin
      queue_op(CMD_READ, sel, data, 1'($urandom_range(0, 1)), drain);
    end else if (r < 90) begin
      queue_op(CMD_TICK, sel, data, 1'($urandom_range(0, 1)), drain);
    end else begin
      if ($urandom_range(0, 3) != 0) data = $urandom_range(0, 15);
      queue_op(CMD_LOAD, sel, data, 1'($urandom_range(0, 1)), drain);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.command       = '0;
    in_ch.reg_select    = '0;
    in_ch.write_data    = '0;
    in_ch.tracking_done = 1'b0;
    out_ch.ready        = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin : drive_p
    bus_op_t     nxt;
    logic        launch;
    logic [31:0] rd;
    logic        irq;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      launch = 1'b0;
      if (in_ch.valid && in_ch.ready) begin
        apply_bus_op(cur_op, rd, irq);
        readback_q.push_back('{rd, irq});
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (stim_q.size() != 0 && !(stim_q[0].drain && readback_q.size() != 0) &&
            $urandom_range(0, 99) >= stim_q[0].idle_pct) begin
          nxt    = stim_q.pop_front();
          cur_op = nxt;
          launch = 1'b1;
          in_ch.command       <= nxt.cmd;
          in_ch.reg_select    <= nxt.sel;
          in_ch.write_data    <= nxt.data;
          in_ch.tracking_done <= nxt.done;
          rx_stall_pct        <= nxt.stall_pct;
        end
        in_ch.valid <= launch;
      end
    end
  end

  always @(posedge clk) begin : check_p
    readback_t exp_r;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      idle_cycles  <= 0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
      if (out_ch.valid && out_ch.ready) begin
        if (readback_q.size() == 0) begin
          $display("%0t unexpected item: expected none, actual read_data %h irq %b",
                   $time, out_ch.read_data, out_ch.irq);
          errors++;
        end else begin
          exp_r = readback_q.pop_front();
          if (out_ch.read_data !== exp_r.rd) begin
            $display("%0t read_data mismatch: expected %h, actual %h",
                     $time, exp_r.rd, out_ch.read_data);
            errors++;
          end
          if (out_ch.irq !== exp_r.irq) begin
            $display("%0t irq mismatch: expected %b, actual %b",
                     $time, exp_r.irq, out_ch.irq);
            errors++;
          end
        end
      end
      if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stimulus_p
    int ph;
    int k;
    for (k = 0; k < 8; k++) queue_op(CMD_READ, sel_t'(k), 32'h0, 1'b0, 1'b0);
    queue_op(CMD_TICK, SEL_NONE, 32'hffff_ffff, 1'b1, 1'b0);
    queue_op(CMD_READ, SEL_MEAS_COUNT, 32'h0, 1'b0, 1'b0);
    queue_op(CMD_WRITE, SEL_ENABLE, 32'hffff_feff, 1'b1, 1'b0);
    queue_op(CMD_READ, SEL_ENABLE, 32'h0, 1'b0, 1'b0);
    queue_op(CMD_WRITE, SEL_ENABLE, 32'h1 << ENABLE_BIT, 1'b0, 1'b0);
    queue_op(CMD_WRITE, SEL_MASK, 32'hffff_ffff, 1'b0, 1'b0);
    queue_op(CMD_WRITE, SEL_MEAS_COUNT, 32'hffff_ffff, 1'b0, 1'b0);
    queue_op(CMD_TICK, SEL_ENABLE, 32'h0, 1'b1, 1'b0);
    queue_op(CMD_WRITE, SEL_FLAGS, 32'hffff_f000, 1'b0, 1'b0);
    queue_op(CMD_READ, SEL_FLAGS, 32'h0, 1'b0, 1'b0);
    queue_op(CMD_WRITE, SEL_FLAGS, 32'hffff_ffff, 1'b0, 1'b0);
    queue_op(CMD_WRITE, SEL_REQ_COUNT, 32'hffff_fc01, 1'b0, 1'b0);
    queue_op(CMD_LOAD, SEL_NONE, 32'hff00_0001, 1'b0, 1'b0);
    queue_op(CMD_TICK, SEL_NONE, 32'h0, 1'b0, 1'b0);
    queue_op(CMD_READ, SEL_FLAGS, 32'h0, 1'b0, 1'b0);
    queue_op(CMD_LOAD, SEL_NONE, 32'h0, 1'b0, 1'b0);
    queue_op(CMD_WRITE, SEL_TRACK_START, 32'hffff_ffff, 1'b1, 1'b0);
    queue_op(CMD_WRITE, SEL_NONE, 32'hffff_ffff, 1'b1, 1'b0);
    queue_op(CMD_READ, SEL_MASK, 32'h0, 1'b0, 1'b0);
    queue_op(CMD_WRITE, SEL_MASK, 32'h0, 1'b0, 1'b0);
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin ph_idle = 0;  ph_stall = 0;  end
        1:       begin ph_idle = 47; ph_stall = 0;  end
        2:       begin ph_idle = 0;  ph_stall = 47; end
        default: begin ph_idle = 9;  ph_stall = 9;  end
      endcase
      for (k = 0; k < 112; k++) queue_random_op(k == 0 || k == 60);
    end
    while (stim_q.size() != 0 || in_ch.valid) @(posedge clk);
    while (readback_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0 && readback_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
